### src/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants, codes and types of the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    localparam int KIND_W     = 2;
    localparam int TICK_W     = 32;
    localparam int SLOT_IN_W  = 8;
    localparam int STATUS_W   = 2;
    localparam int TASK_W     = 6;

    localparam int DIV_W      = TICK_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam logic [TICK_W-1:0] TICK_HALF = {1'b1, {(TICK_W-1){1'b0}}};

    localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENABLE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN      = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PARAM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 2'd3;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

### src/ptd_divider.sv
// ----------------------------------------------------------------------------
// ptd_divider
// Restoring remainder unit: one quotient bit per cycle, done pulses once and
// the remainder holds until the next start.
// ----------------------------------------------------------------------------
module ptd_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  ptd_pkg::div_req_t req,
    output ptd_pkg::div_rsp_t rsp
);
    import ptd_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       diff;

    assign shifted = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // keep the shifted value when the divisor does not fit
            rem_next = diff[DIV_W] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

### src/periodic_task_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Register and set-enable words pass through the execute and final states; a
// run pass scans the slots in order, and each due slot waits for the remainder
// unit that computes the release catch-up and then for any output stall before
// its result is stored; one word is in flight at a time.
// Reset clears the used and enable flags of every slot and empties the output.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ptd_pkg::KIND_W-1:0]      kind,
    input  logic [ptd_pkg::TICK_W-1:0]      now_tick,
    input  logic [ptd_pkg::TICK_W-1:0]      period,
    input  logic                            run_immediately,
    input  logic [ptd_pkg::SLOT_IN_W-1:0]   slot,
    input  logic                            enable,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ptd_pkg::STATUS_W-1:0]    status,
    output logic [ptd_pkg::TASK_W-1:0]      task_slot,
    output logic                            dispatched,
    output logic [ptd_pkg::TICK_W-1:0]      run_count,
    output logic                            last
);
    import ptd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;

    // latched input word
    logic [KIND_W-1:0]     kind_reg;
    logic [TICK_W-1:0]     now_reg;
    logic [TICK_W-1:0]     per_in_reg;
    logic                  imm_reg;
    logic [SLOT_IN_W-1:0]  slot_reg;
    logic                  en_reg;

    // slot table
    logic [TASK_SLOTS-1:0] slot_used_reg, slot_used_next;
    logic [TASK_SLOTS-1:0] slot_on_reg, slot_on_next;
    logic [TICK_W-1:0]     per_reg [TASK_SLOTS];
    logic [TICK_W-1:0]     per_next [TASK_SLOTS];
    logic [TICK_W-1:0]     rel_reg [TASK_SLOTS];
    logic [TICK_W-1:0]     rel_next [TASK_SLOTS];
    logic [TICK_W-1:0]     runs_reg [TASK_SLOTS];
    logic [TICK_W-1:0]     runs_next [TASK_SLOTS];

    // result waiting to be pushed
    logic                  pend_valid_reg, pend_valid_next;
    logic [STATUS_W-1:0]   pend_status_reg, pend_status_next;
    logic [TASK_W-1:0]     pend_slot_reg, pend_slot_next;
    logic                  pend_disp_reg, pend_disp_next;
    logic [TICK_W-1:0]     pend_runs_reg, pend_runs_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [TASK_W-1:0]     out_slot_reg, out_slot_next;
    logic                  out_disp_reg, out_disp_next;
    logic [TICK_W-1:0]     out_runs_reg, out_runs_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_free;
    logic                  push;
    logic                  push_last;

    logic [SLOT_W-1:0]     rd_idx;
    logic [TICK_W-1:0]     sel_per;
    logic [TICK_W-1:0]     sel_rel;
    logic [TICK_W-1:0]     sel_runs;
    logic [TICK_W-1:0]     lag;
    logic [TICK_W-1:0]     neg_per;
    logic [TICK_W-1:0]     adj;
    logic [TICK_W-1:0]     caught_rel;
    logic                  sel_due;
    logic                  scan_last;

    logic [SLOT_W-1:0]     free_idx;
    logic                  free_any;
    logic                  slot_ok;

    div_req_t              div_req;
    div_rsp_t              div_rsp;

    ptd_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rd_idx   = (state_reg == S_EXEC) ? slot_reg[SLOT_W-1:0] : idx_reg;
    assign sel_per  = per_reg[rd_idx];
    assign sel_rel  = rel_reg[rd_idx];
    assign sel_runs = runs_reg[rd_idx];

    assign lag      = now_reg - sel_rel;
    assign neg_per  = '0 - sel_per;
    assign sel_due  = slot_used_reg[idx_reg] && slot_on_reg[idx_reg] && !lag[TICK_W-1];
    assign scan_last = (idx_reg == SLOT_W'(TASK_SLOTS - 1));

    // Short periods: release = now - (lag mod p) + p.
    // Long periods step backward by -p; round the gap to half range up.
    assign adj = (div_rsp.remainder == '0) ? '0 : (neg_per - div_rsp.remainder);
    assign caught_rel = (sel_per == '0) ? sel_rel :
                        !sel_per[TICK_W-1] ? (now_reg - div_rsp.remainder + sel_per) :
                        (now_reg - TICK_HALF - adj);

    assign slot_ok = (slot_reg < SLOT_IN_W'(TASK_SLOTS)) &&
                     slot_used_reg[slot_reg[SLOT_W-1:0]];

    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_used_reg[i])
            begin
                free_idx = SLOT_W'(i);
                free_any = 1'b1;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        slot_used_next   = slot_used_reg;
        slot_on_next     = slot_on_reg;
        per_next         = per_reg;
        rel_next         = rel_reg;
        runs_next        = runs_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_disp_next   = pend_disp_reg;
        pend_runs_next   = pend_runs_reg;
        push             = 1'b0;
        push_last        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                pend_valid_next  = 1'b1;
                pend_status_next = ST_OK;
                pend_slot_next   = '0;
                pend_disp_next   = 1'b0;
                pend_runs_next   = '0;
                state_next       = S_FINAL;
                case (kind_reg)
                    KIND_REGISTER:
                    begin
                        if (per_in_reg == '0)
                        begin
                            pend_status_next = ST_BAD_PARAM;
                        end
                        else if (!free_any)
                        begin
                            pend_status_next = ST_FULL;
                        end
                        else
                        begin
                            slot_used_next[free_idx] = 1'b1;
                            slot_on_next[free_idx]   = 1'b1;
                            per_next[free_idx]       = per_in_reg;
                            rel_next[free_idx]       = imm_reg ? now_reg
                                                               : now_reg + per_in_reg;
                            runs_next[free_idx]      = '0;
                            pend_slot_next           = TASK_W'(free_idx);
                        end
                    end
                    KIND_ENABLE:
                    begin
                        if (!slot_ok)
                        begin
                            pend_status_next = ST_BAD_SLOT;
                        end
                        else
                        begin
                            slot_on_next[rd_idx] = en_reg;
                            if (en_reg)
                            begin
                                rel_next[rd_idx] = now_reg + sel_per;
                            end
                            pend_slot_next = TASK_W'(rd_idx);
                        end
                    end
                    KIND_RUN:
                    begin
                        // idle result stays in pend unless a slot dispatches
                        pend_valid_next = 1'b0;
                        idx_next        = '0;
                        state_next      = S_SCAN;
                    end
                    default:
                    begin
                        pend_status_next = ST_BAD_PARAM;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sel_due)
                begin
                    if (sel_per == '0)
                    begin
                        state_next = S_STORE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        if (!sel_per[TICK_W-1])
                        begin
                            div_req.dividend = lag;
                            div_req.divisor  = sel_per;
                        end
                        else
                        begin
                            div_req.dividend = TICK_HALF - lag;
                            div_req.divisor  = neg_per;
                        end
                        state_next = S_DIV;
                    end
                end
                else if (scan_last)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                // flush the previous dispatch before this one takes its place
                if (!pend_valid_reg || out_free)
                begin
                    push              = pend_valid_reg;
                    rel_next[idx_reg]  = caught_rel;
                    runs_next[idx_reg] = sel_runs + 1'b1;
                    pend_valid_next   = 1'b1;
                    pend_status_next  = ST_OK;
                    pend_slot_next    = TASK_W'(idx_reg);
                    pend_disp_next    = 1'b1;
                    pend_runs_next    = sel_runs + 1'b1;
                    if (scan_last)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_disp_next   = out_disp_reg;
        out_runs_next   = out_runs_reg;
        out_last_next   = out_last_reg;
        if (push)
        begin
            out_valid_next  = 1'b1;
            out_status_next = pend_status_reg;
            out_slot_next   = pend_slot_reg;
            out_disp_next   = pend_disp_reg;
            out_runs_next   = pend_runs_reg;
            out_last_next   = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            slot_used_reg  <= '0;
            slot_on_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            slot_used_reg  <= slot_used_next;
            slot_on_reg    <= slot_on_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg   <= kind;
            now_reg    <= now_tick;
            per_in_reg <= period;
            imm_reg    <= run_immediately;
            slot_reg   <= slot;
            en_reg     <= enable;
        end
        per_reg         <= per_next;
        rel_reg         <= rel_next;
        runs_reg        <= runs_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_disp_reg   <= pend_disp_next;
        pend_runs_reg   <= pend_runs_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_disp_reg    <= out_disp_next;
        out_runs_reg    <= out_runs_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign task_slot  = out_slot_reg;
    assign dispatched = out_disp_reg;
    assign run_count  = out_runs_reg;
    assign last       = out_last_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_EXEC)
        else $error("accepted word did not start execution");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("remainder unit finished outside its wait state");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_DIV |-> !div_rsp.busy)
        else $error("remainder unit busy outside its wait state");

    a_on_needs_used: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_on_reg & ~slot_used_reg) == '0)
        else $error("free slot marked enabled");

    a_dispatch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dispatched |-> status == ST_OK)
        else $error("dispatch result with error status");

endmodule
